// ===== hw/rtl/deq_pkg.sv =====
// Package with the request and response types and codes of the double-ended queue.
package deq_pkg;

  localparam int DefaultDepth = 64;
  localparam int DataWidth    = 16;
  localparam int PosWidth     = 7;
  localparam int LenWidth     = 7;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_FRONT,
    SEL_BACK,
    SEL_READ
  } sel_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    op_t                         op;
    logic signed [DataWidth-1:0] value;
    logic [PosWidth-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] front_value;
    logic signed [DataWidth-1:0] back_value;
    logic signed [DataWidth-1:0] read_value;
    logic [LenWidth-1:0]         length;
    logic                        is_empty;
    status_t                     status;
  } rsp_t;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: control, head and count registers, response register.
//
// A request on the req channel carries an operation (push front, push back, pop front,
// pop back, read at a 1-based position), a value and a position. Each request yields
// exactly one response on the rsp channel with the front and back values, the value
// read, the length, an empty flag and a status. Failed requests change nothing.
// A request is taken when req_valid is high and req_stall is low; a response is taken
// when rsp_valid is high and rsp_stall is low.
// A request is accepted in S_IDLE, where it writes or reads the ring store, and is
// completed in S_EXEC, which uses the registered read data to form the response. The
// registered store read sets this, so no new request is taken until the response
// of the last one is loaded into the output register, which S_EXEC does once that
// register is free. The front and back elements are also kept in registers, so a
// request needs at most one store access.
// While the receiver stalls, the response register holds; a new request is still
// taken and completes as soon as the register frees up.
// Synchronous reset empties the queue and clears all handshakes; the store itself
// is not cleared and needs no clearing pass.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = DefaultDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > PosWidth) ? CW : PosWidth;
  localparam logic [CW-1:0] Full = CW'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  state_t                      state, state_next;
  logic [AW-1:0]               head, head_next;
  logic [CW-1:0]               count, count_next;
  logic signed [DataWidth-1:0] front, front_next;
  logic signed [DataWidth-1:0] back, back_next;
  status_t                     pend_status, pend_status_next;
  sel_t                        pend_sel, pend_sel_next;
  rsp_t                        rsp_next;
  logic                        rsp_valid_next;

  logic                        accept;
  logic                        load;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic                        re;
  logic [AW-1:0]               raddr;
  logic signed [DataWidth-1:0] rdata;
  logic [PW-1:0]               pos_ext;
  logic                        pos_ok;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (AW + 1)'(DEPTH)) begin
      s = s - (AW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  deq_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(req.value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign load      = (state == S_EXEC) && (!rsp_valid || !rsp_stall);
  assign pos_ext   = PW'(req.position);
  assign pos_ok    = (pos_ext != '0) && (pos_ext <= PW'(count));

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    front_next       = front;
    back_next        = back;
    pend_status_next = pend_status;
    pend_sel_next    = pend_sel;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid && rsp_stall;
    we               = 1'b0;
    waddr            = head;
    re               = 1'b0;
    raddr            = head;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next       = S_EXEC;
          pend_status_next = ST_OK;
          pend_sel_next    = SEL_NONE;
          case (req.op)
            OP_PUSH_FRONT: begin
              if (count >= Full) begin
                pend_status_next = ST_FULL;
              end else begin
                head_next  = (head == '0) ? LastSlot : head - AW'(1);
                we         = 1'b1;
                waddr      = head_next;
                count_next = count + CW'(1);
                front_next = req.value;
                if (count == '0) begin
                  back_next = req.value;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (count >= Full) begin
                pend_status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = slot(head, AW'(count));
                count_next = count + CW'(1);
                back_next  = req.value;
                if (count == '0) begin
                  front_next = req.value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (count == '0) begin
                pend_status_next = ST_EMPTY;
              end else begin
                head_next  = slot(head, AW'(1));
                count_next = count - CW'(1);
                if (count > CW'(1)) begin
                  re            = 1'b1;
                  raddr         = head_next;
                  pend_sel_next = SEL_FRONT;
                end
              end
            end
            OP_POP_BACK: begin
              if (count == '0) begin
                pend_status_next = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
                if (count > CW'(1)) begin
                  re            = 1'b1;
                  raddr         = slot(head, AW'(count - CW'(2)));
                  pend_sel_next = SEL_BACK;
                end
              end
            end
            OP_READ: begin
              if (!pos_ok) begin
                pend_status_next = ST_RANGE;
              end else begin
                re            = 1'b1;
                raddr         = slot(head, AW'(pos_ext - PW'(1)));
                pend_sel_next = SEL_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EXEC: begin
        if (load) begin
          state_next = S_IDLE;
          if (pend_sel == SEL_FRONT) begin
            front_next = rdata;
          end
          if (pend_sel == SEL_BACK) begin
            back_next = rdata;
          end
          rsp_valid_next       = 1'b1;
          rsp_next.front_value = (count == '0) ? '0 : front_next;
          rsp_next.back_value  = (count == '0) ? '0 : back_next;
          rsp_next.read_value  = (pend_sel == SEL_READ) ? rdata : '0;
          rsp_next.length      = LenWidth'(count);
          rsp_next.is_empty    = (count == '0);
          rsp_next.status      = pend_status;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    front       <= front_next;
    back        <= back_next;
    pend_status <= pend_status_next;
    pend_sel    <= pend_sel_next;
    rsp         <= rsp_next;
  end

endmodule

// ===== hw/rtl/deq_store.sv =====
// Ring store of the double-ended queue: one write port and one registered read port.
module deq_store
  import deq_pkg::*;
#(
  parameter int DEPTH = DefaultDepth,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic signed [DataWidth-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic signed [DataWidth-1:0] rdata
);

  logic signed [DataWidth-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/deq_checker.sv =====
// Port-level assertions for the double-ended queue and the bind that attaches them.
module deq_checker
  import deq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("Stalled response changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("Request taken while the previous one was still in progress.");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.is_empty == (rsp.length == '0))
    else $error("Empty flag disagrees with the length.");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |-> rsp.front_value == '0 && rsp.back_value == '0)
    else $error("Empty queue reported a front or back value.");

  a_error_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.read_value == '0)
    else $error("Failed request returned a read value.");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

// ===== bench/double_ended_queue_tb.sv =====
// Self-checking testbench for the double-ended queue: directed, capacity, backpressure, random and pause tests.
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int Depth = DefaultDepth;
  localparam int IdxWidth = $clog2(Depth);
  localparam int CycleLimit = 200000;
  localparam int IdlePercent = 13;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic signed [DataWidth-1:0] shadow_store [Depth];
  logic [IdxWidth-1:0] shadow_head = '0;
  logic [LenWidth-1:0] shadow_count = '0;
  rsp_t pending_rsp [$];
  int errors = 0;
  int cycles = 0;
  int hold_len = 0;
  int hold_cnt = 0;
  bit quiet = 1'b0;

  always #1 clk = ~clk;

  double_ended_queue dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  function automatic logic [IdxWidth-1:0] slot_at(logic [LenWidth-1:0] offset);
    return IdxWidth'(shadow_head + offset);
  endfunction

  function automatic rsp_t apply_deque_op(req_t r);
    rsp_t o;
    logic [2:0] code;
    o = '0;
    code = r.op;
    case (code)
      OP_PUSH_FRONT: begin
        if (shadow_count >= Depth) begin
          o.status = ST_FULL;
        end else begin
          shadow_head = shadow_head - 1'b1;
          shadow_store[shadow_head] = r.value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= Depth) begin
          o.status = ST_FULL;
        end else begin
          shadow_store[slot_at(shadow_count)] = r.value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          shadow_head = slot_at(LenWidth'(1));
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_READ: begin
        if (r.position == 0 || r.position > shadow_count) begin
          o.status = ST_RANGE;
        end else begin
          o.read_value = shadow_store[slot_at(LenWidth'(r.position - 1'b1))];
        end
      end
      default: ;
    endcase
    if (shadow_count != 0) begin
      o.front_value = shadow_store[shadow_head];
      o.back_value = shadow_store[slot_at(LenWidth'(shadow_count - 1'b1))];
    end
    o.length = shadow_count;
    o.is_empty = (shadow_count == 0);
    return o;
  endfunction

  function automatic req_t make_req(logic [2:0] code, int value, int position);
    req_t r;
    r.op = op_t'(code);
    r.value = DataWidth'(value);
    r.position = PosWidth'(position);
    return r;
  endfunction

  function automatic req_t random_request(int mode);
    int p;
    int value;
    int position;
    logic [2:0] code;
    p = $urandom_range(99);
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: value = 32767;
        1: value = -32768;
        2: value = 0;
        default: value = -1;
      endcase
    end else begin
      value = $urandom;
    end
    if (shadow_count != 0 && $urandom_range(99) < 75) begin
      position = $urandom_range(shadow_count, 1);
    end else begin
      position = $urandom_range(Depth, 0);
    end
    if (mode == 0) begin
      code = (p < 70) ? OP_PUSH_FRONT : (p < 85) ? OP_READ : OP_POP_FRONT;
    end else if (mode == 1) begin
      code = (p < 70) ? OP_POP_FRONT : (p < 85) ? OP_READ : OP_PUSH_FRONT;
    end else begin
      code = (p < 35) ? OP_PUSH_FRONT : (p < 70) ? OP_POP_FRONT : OP_READ;
    end
    if (code != OP_READ && $urandom_range(1) == 1) begin
      code = code + 3'd1;
    end
    return make_req(code, value, position);
  endfunction

  task automatic send_request(input req_t r);
    if (!quiet) begin
      while ($urandom_range(99) < IdlePercent) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp.push_back(apply_deque_op(r));
  endtask

  task automatic stop_sending();
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(make_req(OP_POP_FRONT, 0, 0));
    send_request(make_req(OP_POP_BACK, 0, 0));
    send_request(make_req(OP_READ, 0, 0));
    send_request(make_req(OP_READ, 0, 1));
    send_request(make_req(3'd5, 123, 1));
    send_request(make_req(OP_PUSH_FRONT, 32767, 0));
    send_request(make_req(OP_PUSH_BACK, -32768, 127));
    send_request(make_req(OP_PUSH_FRONT, 0, 0));
    send_request(make_req(OP_PUSH_BACK, -1, 0));
    send_request(make_req(OP_READ, 0, 1));
    send_request(make_req(OP_READ, 0, 4));
    send_request(make_req(OP_READ, 0, 5));
    send_request(make_req(OP_READ, 0, 0));
    send_request(make_req(OP_READ, 0, 64));
    send_request(make_req(3'd6, -1, 2));
    send_request(make_req(3'd7, 0, 64));
    send_request(make_req(OP_POP_FRONT, 0, 0));
    send_request(make_req(OP_POP_BACK, 0, 0));
    send_request(make_req(OP_READ, 0, 2));
    send_request(make_req(OP_POP_FRONT, 0, 0));
    send_request(make_req(OP_POP_BACK, 0, 0));
    send_request(make_req(OP_POP_BACK, 0, 0));
  endtask

  // Fill the queue to capacity from both ends, push into the full queue, then drain it.
  task automatic test_capacity();
    while (shadow_count < Depth) begin
      send_request(make_req($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom, 0));
    end
    send_request(make_req(OP_PUSH_FRONT, 1, 0));
    send_request(make_req(OP_PUSH_BACK, -2, 0));
    send_request(make_req(OP_READ, 0, Depth));
    send_request(make_req(OP_READ, 0, 1));
    send_request(make_req(OP_PUSH_BACK, 32767, 0));
    while (shadow_count != 0) begin
      send_request(make_req($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, 0, 0));
    end
    send_request(make_req(OP_POP_FRONT, 0, 0));
    send_request(make_req(OP_POP_BACK, 0, 0));
  endtask

  task automatic test_random(input int count);
    int mode;
    int run;
    int sent;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(2);
      run = $urandom_range(120, 20);
      quiet = (sent >= count / 2 && sent < count / 2 + 300);
      repeat (run) begin
        send_request(random_request(mode));
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  // The receiver holds off while requests keep coming, so the block backs up and stalls.
  task automatic test_backpressure();
    hold_len = 400;
    repeat (80) send_request(random_request(2));
  endtask

  task automatic test_pause();
    repeat (40) send_request(random_request(0));
    stop_sending();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) send_request(random_request(1));
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : response_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.front_value !== want.front_value || rsp.back_value !== want.back_value ||
            rsp.read_value !== want.read_value || rsp.length !== want.length ||
            rsp.is_empty !== want.is_empty || rsp.status !== want.status) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected front %0d back %0d read %0d len %0d empty %0b st %0d",
                     want.front_value, want.back_value, want.read_value, want.length,
                     want.is_empty, want.status);
            $display("          got      front %0d back %0d read %0d len %0d empty %0b st %0d",
                     rsp.front_value, rsp.back_value, rsp.read_value, rsp.length,
                     rsp.is_empty, rsp.status);
          end
        end
      end
    end
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(99) < IdlePercent);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random(1500);
    test_pause();
    stop_sending();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_store.sv
hw/rtl/double_ended_queue.sv
hw/rtl/deq_checker.sv
bench/double_ended_queue_tb.sv
